// ===== hw/rtl/frd_pkg.sv =====
// Shared types and constants of the frame descriptor ring.
// No dependencies; imported by the ring top level and its testbench.
package frd_pkg;

   localparam int RING_DEPTH = 16;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_COMMIT  = 2'd1;
   localparam logic [1:0] CMD_POP     = 2'd2;
   localparam logic [1:0] CMD_RESET   = 2'd3;

   localparam logic CSR_BUFFER_BASE = 1'b0;
   localparam logic CSR_FRAME_SIZE  = 1'b1;

   localparam logic [11:0] FRAME_SIZE_RESET = 12'd1536;
   localparam logic [15:0] MAX_FRAME_BYTES  = 16'd2048;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  slot_index;
      logic [31:0] slot_address;
      logic [15:0] slot_bytes;
      logic [4:0]  occupancy;
   } rsp_type;

endpackage

// ===== hw/rtl/frd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the slot length store.
module frd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/frame_descriptor_ring_unit.sv =====
// Top level of the frame descriptor ring: command decode, pointers, slot store.
// Depends on frd_pkg and frd_ram.
//
//   channel | ports           | direction | transfer when
//   --------+-----------------+-----------+--------------------------
//   req     | req_payload     | in        | req_valid && req_ready
//   rsp     | rsp_payload     | out       | rsp_valid && rsp_ready
//   csr     | csr_index/data  | in        | csr_write_en
//
// One command per cycle while results are not stalled; a result passes the decode
// stage and then the result register. The decode stage lines up with the registered
// read of the slot length RAM on pop. Reset is synchronous; per-slot valid bits let
// a reset command clear the ring, so there is no clearing pass.
// A stalled result holds the decode stage, which then drops req_ready.
module frame_descriptor_ring_unit
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

   logic [31:0] buffer_base_ff;
   logic [11:0] frame_size_ff;
   logic [15:0] eff_size;

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [RING_DEPTH-1:0] slot_valid_ff, slot_valid_in;

   logic             accept;
   logic             not_full;
   logic             dec_status;
   logic [PTR_W-1:0] dec_idx;
   logic             ram_we;
   logic             ram_re;
   logic [15:0]      ram_rd_data;

   logic             s1_valid_ff;
   logic             s1_status_ff;
   logic [1:0]       s1_cmd_ff;
   logic [PTR_W-1:0] s1_idx_ff;
   logic [CNT_W-1:0] s1_count_ff;
   logic             s1_vbit_ff;
   logic             advance;

   logic [PTR_W+15:0] product;
   rsp_type           rsp_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_base_ff <= '0;
         frame_size_ff  <= FRAME_SIZE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BUFFER_BASE: buffer_base_ff <= csr_write_data;
            CSR_FRAME_SIZE:  frame_size_ff  <= csr_write_data[11:0];
            default:         buffer_base_ff <= buffer_base_ff;
         endcase
      end
   end

   assign eff_size = ({4'b0, frame_size_ff} > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES
                                                              : {4'b0, frame_size_ff};

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign not_full  = count_ff < DEPTH_CNT;

   // command decode against the current ring state
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      slot_valid_in = slot_valid_ff;
      dec_status    = 1'b1;
      dec_idx       = '0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      case (req_payload.command)
         CMD_ACQUIRE: begin
            if (not_full) begin
               dec_status = 1'b0;
               dec_idx    = tail_ff;
            end
         end
         CMD_COMMIT: begin
            if (not_full && (req_payload.frame_length <= eff_size)) begin
               dec_status             = 1'b0;
               ram_we                 = accept;
               slot_valid_in[tail_ff] = 1'b1;
               tail_in                = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
               count_in               = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (count_ff != '0) begin
               dec_status = 1'b0;
               dec_idx    = head_ff;
               ram_re     = accept;
               head_in    = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         default: begin
            dec_status    = 1'b0;
            head_in       = '0;
            tail_in       = '0;
            count_in      = '0;
            slot_valid_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         slot_valid_ff <= '0;
      end else if (accept) begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   frd_ram #(
      .WIDTH (16),
      .DEPTH (RING_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (req_payload.frame_length),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // decode stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= dec_status;
         s1_cmd_ff    <= req_payload.command;
         s1_idx_ff    <= dec_idx;
         s1_count_ff  <= count_in;
         s1_vbit_ff   <= slot_valid_ff[head_ff];
      end
   end

   // result formation
   assign product = s1_idx_ff * eff_size;

   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = s1_status_ff;
      rsp_in.slot_index   = 4'(s1_idx_ff);
      rsp_in.occupancy    = 5'(s1_count_ff);
      if (!s1_status_ff) begin
         case (s1_cmd_ff)
            CMD_ACQUIRE: begin
               rsp_in.slot_address = buffer_base_ff + 32'(product);
               rsp_in.slot_bytes   = eff_size;
            end
            CMD_POP: begin
               rsp_in.slot_address = buffer_base_ff + 32'(product);
               rsp_in.slot_bytes   = s1_vbit_ff ? ram_rd_data : 16'd0;
            end
            default: begin
               rsp_in.slot_address = '0;
               rsp_in.slot_bytes   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("fill count above ring depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == DEPTH_CNT) |-> head_ff == tail_ff)
      else $error("head and tail disagree with an empty or full ring");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status) |->
         (rsp_payload.slot_index == '0 && rsp_payload.slot_address == '0
          && rsp_payload.slot_bytes == '0))
      else $error("refused result carries slot data");

   a_commit_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.command == CMD_COMMIT && not_full
       && req_payload.frame_length <= eff_size) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("commit did not advance the fill count");
`endif

endmodule

// ===== tb/frame_descriptor_ring_unit_test.sv =====
// Testbench for frame_descriptor_ring_unit: directed and random command traffic,
// with each result checked against an in-bench model of the slot ring.
// Depends on frd_pkg and the frame_descriptor_ring_unit RTL.
module frame_descriptor_ring_unit_test;
   import frd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int       RING_SLOTS      = 16;
   localparam int       RSP_HOLD_CYCLES = 300;
   localparam int       PHASE_ITEMS     = 85;
   localparam logic     STATUS_OK       = 1'b0;
   localparam logic     STATUS_REFUSED  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_BUFFER_BASE;
   logic [31:0] csr_write_data = '0;

   // model of the ring
   logic [31:0] cfg_base;
   logic [11:0] cfg_frame_size;
   logic [3:0]  ring_head;
   logic [3:0]  ring_tail;
   logic [4:0]  ring_fill;
   logic [15:0] stored_len [RING_SLOTS];

   rsp_type     ring_expected [$];
   int          fail_count = 0;
   bit          idle_enable = 1'b1;
   bit          hold_request = 1'b0;

   frame_descriptor_ring_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] ring_capacity();
      if (cfg_frame_size > MAX_FRAME_BYTES) begin
         return MAX_FRAME_BYTES;
      end
      return {4'b0, cfg_frame_size};
   endfunction

   function automatic logic [31:0] slot_base_address(logic [3:0] slot);
      return cfg_base + {28'b0, slot} * {16'b0, ring_capacity()};
   endfunction

   function automatic void clear_ring_model();
      ring_head = '0;
      ring_tail = '0;
      ring_fill = '0;
      foreach (stored_len[i]) stored_len[i] = '0;
   endfunction

   function automatic rsp_type predict_ring_step(req_type item);
      rsp_type     res;
      logic [15:0] cap;
      cap = ring_capacity();
      res = '0;
      res.status = STATUS_REFUSED;
      case (item.command)
         CMD_ACQUIRE: begin
            if (ring_fill < RING_SLOTS) begin
               res.status       = STATUS_OK;
               res.slot_index   = ring_tail;
               res.slot_address = slot_base_address(ring_tail);
               res.slot_bytes   = cap;
            end
         end
         CMD_COMMIT: begin
            if (ring_fill < RING_SLOTS && item.frame_length <= cap) begin
               res.status            = STATUS_OK;
               stored_len[ring_tail] = item.frame_length;
               ring_tail             = ring_tail + 4'd1;
               ring_fill             = ring_fill + 5'd1;
            end
         end
         CMD_POP: begin
            if (ring_fill != 0) begin
               res.status       = STATUS_OK;
               res.slot_index   = ring_head;
               res.slot_address = slot_base_address(ring_head);
               res.slot_bytes   = stored_len[ring_head];
               ring_head        = ring_head + 4'd1;
               ring_fill        = ring_fill - 5'd1;
            end
         end
         default: begin
            res.status = STATUS_OK;
            clear_ring_model();
         end
      endcase
      res.occupancy = ring_fill;
      return res;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ring_expected.size() == 0) begin
            $error("result transfer with no expected result pending");
            fail_count++;
         end else begin
            exp = ring_expected.pop_front();
            compare_field("status", exp.status, rsp_payload.status);
            compare_field("slot_index", exp.slot_index, rsp_payload.slot_index);
            compare_field("slot_address", exp.slot_address, rsp_payload.slot_address);
            compare_field("slot_bytes", exp.slot_bytes, rsp_payload.slot_bytes);
            compare_field("occupancy", exp.occupancy, rsp_payload.occupancy);
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin : drive_rsp_ready
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, 10);
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_cmd(logic [1:0] cmd, logic [15:0] len);
      req_type item;
      item.command      = cmd;
      item.frame_length = len;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ring_expected.push_back(predict_ring_step(item));
   endtask

   task automatic wait_ring_idle();
      req_valid <= 1'b0;
      while (ring_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_ring_config(logic [31:0] base, logic [31:0] size_data);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_BUFFER_BASE;
      csr_write_data <= base;
      @(posedge clock);
      csr_index      <= CSR_FRAME_SIZE;
      csr_write_data <= size_data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg_base       = base;
      cfg_frame_size = size_data[11:0];
   endtask

   task automatic test_directed_basics();
      send_cmd(CMD_POP, 16'h0000);
      send_cmd(CMD_ACQUIRE, 16'hFFFF);
      send_cmd(CMD_COMMIT, 16'd1536);
      send_cmd(CMD_COMMIT, 16'd1537);
      send_cmd(CMD_COMMIT, 16'hFFFF);
      send_cmd(CMD_COMMIT, 16'd0);
      send_cmd(CMD_ACQUIRE, 16'h0000);
      send_cmd(CMD_POP, 16'hFFFF);
      send_cmd(CMD_POP, 16'h0000);
      send_cmd(CMD_POP, 16'h0000);
      send_cmd(CMD_COMMIT, 16'd100);
      send_cmd(CMD_RESET, 16'hFFFF);
      send_cmd(CMD_POP, 16'h0000);
      wait_ring_idle();
   endtask

   task automatic test_config_extremes();
      // oversized frame size saturates, addresses wrap past 2^32
      set_ring_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(CMD_COMMIT, MAX_FRAME_BYTES);
      send_cmd(CMD_COMMIT, MAX_FRAME_BYTES + 16'd1);
      send_cmd(CMD_ACQUIRE, 16'h0000);
      send_cmd(CMD_POP, 16'h0000);
      wait_ring_idle();
      // zero frame size: no capacity, every slot at the base
      set_ring_config(32'h8000_0000, 32'hABCD_E000);
      send_cmd(CMD_ACQUIRE, 16'h0000);
      send_cmd(CMD_COMMIT, 16'd1);
      send_cmd(CMD_COMMIT, 16'd0);
      send_cmd(CMD_ACQUIRE, 16'h0000);
      send_cmd(CMD_POP, 16'h0000);
      wait_ring_idle();
      set_ring_config(32'h0000_0000, 32'h0000_0001);
      send_cmd(CMD_COMMIT, 16'd1);
      send_cmd(CMD_POP, 16'h0000);
      wait_ring_idle();
   endtask

   task automatic test_backpressure_fill();
      set_ring_config($urandom(), 32'd64);
      idle_enable  = 1'b0;
      hold_request = 1'b1;
      send_cmd(CMD_RESET, 16'h0000);
      repeat (20) send_cmd(CMD_COMMIT, 16'($urandom_range(0, 64)));
      repeat (2) send_cmd(CMD_ACQUIRE, 16'h0000);
      repeat (20) send_cmd(CMD_POP, 16'h0000);
      wait_ring_idle();
      idle_enable = 1'b1;
   endtask

   task automatic run_random_traffic(int n, bit quiet);
      int          r;
      int          k;
      int          fill_pct;
      logic [15:0] cap;
      logic [15:0] len;
      fill_pct = 50;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            idle_enable = quiet ? 1'b0 : ($urandom_range(0, 2) != 0);
            fill_pct    = $urandom_range(25, 70);
         end
         r   = $urandom_range(0, 99);
         cap = ring_capacity();
         if (r < 8) begin
            send_cmd(2'($urandom_range(0, 3)), 16'($urandom()));
         end else if (r < 10) begin
            send_cmd(CMD_RESET, 16'($urandom()));
         end else if (r < 10 + fill_pct) begin
            k = $urandom_range(0, 9);
            if (k < 6) begin
               len = 16'($urandom_range(0, cap));
            end else if (k == 6) begin
               len = cap;
            end else if (k == 7) begin
               len = cap + 16'd1;
            end else if (k == 8) begin
               len = 16'($urandom());
            end else begin
               len = 16'd0;
            end
            send_cmd(CMD_ACQUIRE, 16'($urandom()));
            send_cmd(CMD_COMMIT, len);
         end else begin
            send_cmd(CMD_POP, 16'($urandom()));
         end
      end
   endtask

   task automatic test_random_configs();
      set_ring_config($urandom(), {20'($urandom_range(0, 1048575)), 12'd1536});
      run_random_traffic(PHASE_ITEMS, 1'b0);
      wait_ring_idle();
      set_ring_config(32'hFFFF_FFFF, 32'd2048);
      run_random_traffic(PHASE_ITEMS, 1'b0);
      wait_ring_idle();
      set_ring_config($urandom(), 32'd1);
      run_random_traffic(PHASE_ITEMS, 1'b0);
      wait_ring_idle();
      set_ring_config($urandom(), 32'($urandom_range(2049, 4095)));
      run_random_traffic(PHASE_ITEMS, 1'b0);
      wait_ring_idle();
      set_ring_config($urandom(), 32'd0);
      run_random_traffic(PHASE_ITEMS, 1'b0);
      wait_ring_idle();
   endtask

   task automatic test_quiet_tail();
      set_ring_config($urandom(), 32'($urandom_range(1, 2048)));
      run_random_traffic(PHASE_ITEMS, 1'b1);
      wait_ring_idle();
   endtask

   initial begin
      cfg_base       = '0;
      cfg_frame_size = FRAME_SIZE_RESET;
      clear_ring_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_config_extremes();
      test_backpressure_fill();
      test_random_configs();
      test_quiet_tail();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && ring_expected.size() == 0) begin
         $display("** frame_descriptor_ring_unit: PASSED **");
      end else begin
         $display("** frame_descriptor_ring_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** frame_descriptor_ring_unit: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/frd_pkg.sv
hw/rtl/frd_ram.sv
hw/rtl/frame_descriptor_ring_unit.sv
tb/frame_descriptor_ring_unit_test.sv
